// ----- hw/rtl/abpp_pkg.sv -----
// Shared constants, types and helpers for the AR(1) ball position predictor.
// No dependencies; imported by ar1_ball_position_predictor.

package abpp_pkg;

   localparam int WINDOW_DEF     = 10;
   localparam int COORD_BITS_DEF = 11;
   localparam int THETA_FRAC_DEF = 16;

   localparam int POS_W   = 11;
   localparam int LIMIT_W = 11;
   localparam int FC_W    = 16;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd2047;
   localparam logic [FC_W-1:0]    FC_MAX      = 16'h7FFF;

   typedef enum logic [1:0] {
      ACC_NONE = 2'd0,
      ACC_DEN  = 2'd1,
      ACC_NUM  = 2'd2
   } acc_dst_type;

   function automatic logic [FC_W-1:0] sat_fc(input logic [63:0] v);
      return (v > 64'(FC_MAX)) ? FC_MAX : v[FC_W-1:0];
   endfunction

endpackage

// ----- hw/rtl/ar1_ball_position_predictor.sv -----
// AR(1) least-squares ball position predictor: sample windows, one shared multiplier,
// a bit-serial divider and a one-hot sequencer. Depends on abpp_pkg.
// Refit beats (phase 0) sum and divide on each axis and refit its forecasts before the
// distance check (the divider is skipped on a zero or saturating ratio); others only check.
// One beat at a time: the next beat can be accepted once the result loads, later while
// rsp_stall holds the output. Synchronous reset clears windows, forecasts, phase.

module ar1_ball_position_predictor
   import abpp_pkg::*;
#(
   parameter int WINDOW     = WINDOW_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int THETA_FRAC = THETA_FRAC_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [POS_W-1:0]       req_pos_x,
   input  logic [POS_W-1:0]       req_pos_y,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [FC_W-1:0] rsp_near_x,
   output logic signed [FC_W-1:0] rsp_near_y,
   output logic signed [FC_W-1:0] rsp_mid_x,
   output logic signed [FC_W-1:0] rsp_mid_y,
   output logic signed [FC_W-1:0] rsp_far_x,
   output logic signed [FC_W-1:0] rsp_far_y,
   output logic                   rsp_recomputed,
   output logic                   rsp_snapped,
   input  logic                   csr_wr_en,
   input  logic [LIMIT_W-1:0]     csr_wr_data
);

   localparam int THETA_W   = 8 + THETA_FRAC;
   localparam int MB        = (THETA_FRAC > FC_W) ? THETA_FRAC : FC_W;
   localparam int MUL_W     = THETA_W + MB;
   localparam int SUM_W     = 2 * COORD_BITS + $clog2(WINDOW);
   localparam int SUM_STEPS = 2 * (WINDOW - 2);
   localparam int CNT_MAX   = (SUM_STEPS > THETA_W) ? SUM_STEPS : THETA_W;
   localparam int CNT_W     = $clog2(CNT_MAX + 1);
   localparam int D2_W      = 2 * FC_W + 1;

   typedef enum logic [18:0] {
      ST_IDLE  = 19'd1 << 0,
      ST_LOAD  = 19'd1 << 1,
      ST_SUM   = 19'd1 << 2,
      ST_DRAIN = 19'd1 << 3,
      ST_DIVI  = 19'd1 << 4,
      ST_DIV   = 19'd1 << 5,
      ST_F1A   = 19'd1 << 6,
      ST_F1B   = 19'd1 << 7,
      ST_F1C   = 19'd1 << 8,
      ST_F1D   = 19'd1 << 9,
      ST_F2A   = 19'd1 << 10,
      ST_F2B   = 19'd1 << 11,
      ST_F3A   = 19'd1 << 12,
      ST_F3B   = 19'd1 << 13,
      ST_DA    = 19'd1 << 14,
      ST_DB    = 19'd1 << 15,
      ST_DC    = 19'd1 << 16,
      ST_DD    = 19'd1 << 17,
      ST_DONE  = 19'd1 << 18
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               axis_ff, axis_in;
   logic [1:0]         phase_ff, phase_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [COORD_BITS-1:0] win_x_ff [WINDOW];
   logic [COORD_BITS-1:0] win_x_in [WINDOW];
   logic [COORD_BITS-1:0] win_y_ff [WINDOW];
   logic [COORD_BITS-1:0] win_y_in [WINDOW];
   logic [COORD_BITS-1:0] scan_ff [WINDOW];
   logic [COORD_BITS-1:0] scan_in [WINDOW];
   logic [COORD_BITS-1:0] px_ff, px_in, py_ff, py_in;
   logic               recomp_ff, recomp_in;
   logic [SUM_W-1:0]   den_ff, den_in, num_ff, num_in;
   acc_dst_type        acc_dst_ff, acc_dst_in;
   logic [MUL_W-1:0]   mul_ff, mul_in;
   logic [THETA_W-1:0] theta_ff, theta_in;
   logic [SUM_W-1:0]   rem_ff, rem_in;
   logic [THETA_W-1:0] dvd_ff, dvd_in;
   logic [THETA_FRAC-1:0] lo_ff, lo_in;
   logic               hibig_ff, hibig_in;
   logic [MUL_W-1:0]   tmp_ff, tmp_in;
   logic [FC_W-1:0]    fc_x_ff [3];
   logic [FC_W-1:0]    fc_x_in [3];
   logic [FC_W-1:0]    fc_y_ff [3];
   logic [FC_W-1:0]    fc_y_in [3];
   logic [D2_W-1:0]    d2_ff, d2_in;
   logic               snap_ff, snap_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FC_W-1:0]    out_ff [6];
   logic [FC_W-1:0]    out_in [6];
   logic               out_recomp_ff, out_recomp_in;
   logic               out_snap_ff, out_snap_in;

   logic [THETA_W-1:0] mul_a;
   logic [MB-1:0]      mul_b;
   logic               req_acc;
   logic [SUM_W:0]     trial;
   logic               trial_ge;
   logic [MUL_W-THETA_FRAC-1:0] hi;
   logic [MUL_W:0]     t_sum;
   logic [FC_W-1:0]    f1_val, fn_val;
   logic [FC_W:0]      dx_diff, dy_diff;
   logic [FC_W-1:0]    dx_mag, dy_mag;
   logic [COORD_BITS-1:0] newest;
   logic [FC_W-1:0]    fc0_sel, fc1_sel;
   logic [FC_W-1:0]    pxw, pyw;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;

   assign newest  = axis_ff ? win_y_ff[WINDOW-1] : win_x_ff[WINDOW-1];
   assign fc0_sel = axis_ff ? fc_y_ff[0] : fc_x_ff[0];
   assign fc1_sel = axis_ff ? fc_y_ff[1] : fc_x_ff[1];
   assign pxw     = FC_W'(px_ff);
   assign pyw     = FC_W'(py_ff);

   assign dx_diff = {1'b0, pxw} - {1'b0, fc_x_ff[2]};
   assign dy_diff = {1'b0, pyw} - {1'b0, fc_y_ff[2]};
   assign dx_mag  = dx_diff[FC_W] ? FC_W'(-dx_diff) : dx_diff[FC_W-1:0];
   assign dy_mag  = dy_diff[FC_W] ? FC_W'(-dy_diff) : dy_diff[FC_W-1:0];

   assign trial    = {rem_ff, dvd_ff[THETA_W-1]};
   assign trial_ge = (trial >= {1'b0, den_ff});
   assign hi       = mul_ff[MUL_W-1:THETA_FRAC];
   assign t_sum    = (MUL_W+1)'(tmp_ff) + (MUL_W+1)'(hi);
   assign f1_val   = hibig_ff ? FC_MAX : sat_fc(64'(t_sum >> THETA_FRAC));
   assign fn_val   = sat_fc(64'(hi));

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_SUM: begin
            mul_a = THETA_W'(scan_ff[0]);
            mul_b = cnt_ff[0] ? MB'(scan_ff[1]) : MB'(scan_ff[0]);
         end
         ST_F1A: begin
            mul_a = theta_ff;
            mul_b = MB'(newest);
         end
         ST_F1B: begin
            mul_a = theta_ff;
            mul_b = MB'(hi[FC_W-1:0]);
         end
         ST_F1C: begin
            mul_a = theta_ff;
            mul_b = MB'(lo_ff);
         end
         ST_F2A: begin
            mul_a = theta_ff;
            mul_b = MB'(fc0_sel);
         end
         ST_F3A: begin
            mul_a = theta_ff;
            mul_b = MB'(fc1_sel);
         end
         ST_DA: begin
            mul_a = THETA_W'(dx_mag);
            mul_b = MB'(dx_mag);
         end
         ST_DB: begin
            mul_a = THETA_W'(dy_mag);
            mul_b = MB'(dy_mag);
         end
         ST_DC: begin
            mul_a = THETA_W'(limit_ff);
            mul_b = MB'(limit_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_in = MUL_W'(mul_a) * MUL_W'(mul_b);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      axis_in       = axis_ff;
      phase_in      = phase_ff;
      limit_in      = csr_wr_en ? csr_wr_data : limit_ff;
      win_x_in      = win_x_ff;
      win_y_in      = win_y_ff;
      scan_in       = scan_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      recomp_in     = recomp_ff;
      den_in        = den_ff;
      num_in        = num_ff;
      acc_dst_in    = ACC_NONE;
      theta_in      = theta_ff;
      rem_in        = rem_ff;
      dvd_in        = dvd_ff;
      lo_in         = lo_ff;
      hibig_in      = hibig_ff;
      tmp_in        = tmp_ff;
      fc_x_in       = fc_x_ff;
      fc_y_in       = fc_y_ff;
      d2_in         = d2_ff;
      snap_in       = snap_ff;
      out_in        = out_ff;
      out_recomp_in = out_recomp_ff;
      out_snap_in   = out_snap_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      unique case (acc_dst_ff)
         ACC_DEN: den_in = den_ff + SUM_W'(mul_ff[2*COORD_BITS-1:0]);
         ACC_NUM: num_in = num_ff + SUM_W'(mul_ff[2*COORD_BITS-1:0]);
         default: begin
         end
      endcase

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               for (int i = 0; i < WINDOW - 1; i++) begin
                  win_x_in[i] = win_x_ff[i+1];
                  win_y_in[i] = win_y_ff[i+1];
               end
               win_x_in[WINDOW-1] = COORD_BITS'(req_pos_x);
               win_y_in[WINDOW-1] = COORD_BITS'(req_pos_y);
               px_in     = COORD_BITS'(req_pos_x);
               py_in     = COORD_BITS'(req_pos_y);
               recomp_in = (phase_ff == 2'd0);
               phase_in  = (phase_ff >= 2'd2) ? 2'd0 : phase_ff + 2'd1;
               axis_in   = 1'b0;
               state_in  = (phase_ff == 2'd0) ? ST_LOAD : ST_DA;
            end
         end
         ST_LOAD: begin
            for (int i = 0; i < WINDOW; i++) begin
               scan_in[i] = axis_ff ? win_y_ff[i] : win_x_ff[i];
            end
            den_in   = '0;
            num_in   = '0;
            cnt_in   = '0;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            acc_dst_in = cnt_ff[0] ? ACC_NUM : ACC_DEN;
            if (cnt_ff[0]) begin
               for (int i = 0; i < WINDOW - 1; i++) begin
                  scan_in[i] = scan_ff[i+1];
               end
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(SUM_STEPS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DIVI;
         end
         ST_DIVI: begin
            cnt_in = '0;
            priority if (den_ff == '0) begin
               theta_in = '0;
               state_in = ST_F1A;
            end else if ({8'd0, num_ff} >= {den_ff, 8'd0}) begin
               theta_in = {THETA_W{1'b1}};
               state_in = ST_F1A;
            end else begin
               theta_in = '0;
               rem_in   = SUM_W'(num_ff >> 8);
               dvd_in   = {num_ff[7:0], {THETA_FRAC{1'b0}}};
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in   = trial_ge ? SUM_W'(trial - {1'b0, den_ff}) : trial[SUM_W-1:0];
            theta_in = {theta_ff[THETA_W-2:0], trial_ge};
            dvd_in   = {dvd_ff[THETA_W-2:0], 1'b0};
            cnt_in   = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(THETA_W - 1)) begin
               state_in = ST_F1A;
            end
         end
         ST_F1A: begin
            state_in = ST_F1B;
         end
         ST_F1B: begin
            lo_in    = mul_ff[THETA_FRAC-1:0];
            hibig_in = (hi >> FC_W) != '0;
            state_in = ST_F1C;
         end
         ST_F1C: begin
            tmp_in   = mul_ff;
            state_in = ST_F1D;
         end
         ST_F1D: begin
            if (axis_ff) fc_y_in[0] = f1_val;
            else         fc_x_in[0] = f1_val;
            state_in = ST_F2A;
         end
         ST_F2A: begin
            state_in = ST_F2B;
         end
         ST_F2B: begin
            if (axis_ff) fc_y_in[1] = fn_val;
            else         fc_x_in[1] = fn_val;
            state_in = ST_F3A;
         end
         ST_F3A: begin
            state_in = ST_F3B;
         end
         ST_F3B: begin
            if (axis_ff) fc_y_in[2] = fn_val;
            else         fc_x_in[2] = fn_val;
            axis_in  = 1'b1;
            state_in = axis_ff ? ST_DA : ST_LOAD;
         end
         ST_DA: begin
            state_in = ST_DB;
         end
         ST_DB: begin
            d2_in    = D2_W'(mul_ff[2*FC_W-1:0]);
            state_in = ST_DC;
         end
         ST_DC: begin
            d2_in    = d2_ff + D2_W'(mul_ff[2*FC_W-1:0]);
            state_in = ST_DD;
         end
         ST_DD: begin
            snap_in  = d2_ff > D2_W'(mul_ff[2*LIMIT_W-1:0]);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               if (snap_ff) begin
                  for (int i = 0; i < 3; i++) begin
                     fc_x_in[i] = pxw;
                     fc_y_in[i] = pyw;
                  end
               end
               out_in[0]     = snap_ff ? pxw : fc_x_ff[0];
               out_in[1]     = snap_ff ? pyw : fc_y_ff[0];
               out_in[2]     = snap_ff ? pxw : fc_x_ff[1];
               out_in[3]     = snap_ff ? pyw : fc_y_ff[1];
               out_in[4]     = snap_ff ? pxw : fc_x_ff[2];
               out_in[5]     = snap_ff ? pyw : fc_y_ff[2];
               out_recomp_in = recomp_ff;
               out_snap_in   = snap_ff;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         axis_ff      <= 1'b0;
         phase_ff     <= 2'd0;
         limit_ff     <= LIMIT_RESET;
         acc_dst_ff   <= ACC_NONE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WINDOW; i++) begin
            win_x_ff[i] <= '0;
            win_y_ff[i] <= '0;
         end
         for (int i = 0; i < 3; i++) begin
            fc_x_ff[i] <= '0;
            fc_y_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         axis_ff      <= axis_in;
         phase_ff     <= phase_in;
         limit_ff     <= limit_in;
         acc_dst_ff   <= acc_dst_in;
         rsp_valid_ff <= rsp_valid_in;
         win_x_ff     <= win_x_in;
         win_y_ff     <= win_y_in;
         fc_x_ff      <= fc_x_in;
         fc_y_ff      <= fc_y_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      recomp_ff     <= recomp_in;
      den_ff        <= den_in;
      num_ff        <= num_in;
      mul_ff        <= mul_in;
      theta_ff      <= theta_in;
      rem_ff        <= rem_in;
      dvd_ff        <= dvd_in;
      lo_ff         <= lo_in;
      hibig_ff      <= hibig_in;
      tmp_ff        <= tmp_in;
      d2_ff         <= d2_in;
      snap_ff       <= snap_in;
      out_ff        <= out_in;
      out_recomp_ff <= out_recomp_in;
      out_snap_ff   <= out_snap_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_near_x     = $signed(out_ff[0]);
   assign rsp_near_y     = $signed(out_ff[1]);
   assign rsp_mid_x      = $signed(out_ff[2]);
   assign rsp_mid_y      = $signed(out_ff[3]);
   assign rsp_far_x      = $signed(out_ff[4]);
   assign rsp_far_y      = $signed(out_ff[5]);
   assign rsp_recomputed = out_recomp_ff;
   assign rsp_snapped    = out_snap_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("sequencer did not leave idle after an accepted beat");

   a_snap_flat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_snapped) |->
         (rsp_near_x == rsp_far_x) && (rsp_near_y == rsp_far_y) &&
         (rsp_mid_x == rsp_far_x) && (rsp_mid_y == rsp_far_y))
      else $error("snapped result carries differing forecasts");

   a_fit_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_recomputed && !rsp_snapped) |->
         !rsp_near_x[FC_W-1] && !rsp_near_y[FC_W-1] && !rsp_mid_x[FC_W-1] &&
         !rsp_mid_y[FC_W-1] && !rsp_far_x[FC_W-1] && !rsp_far_y[FC_W-1])
      else $error("refitted forecast beyond saturation limit");

endmodule
